/* rtl/hbt_pkg.sv */
// Shared types, constants and helper functions for the histogram bin table.
package hbt_pkg;

	// Table geometry and count widths.
	localparam int BIN_CAPACITY = 1024;
	localparam int COUNT_WIDTH  = 32;
	localparam int ADDR_W       = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1;
	localparam int IN_USE_W     = $clog2(BIN_CAPACITY + 1);
	localparam int TOTAL_W      = 48;
	localparam int WIDE_W       = TOTAL_W + 1;

	// Fixed field widths of the beats.
	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 10;
	localparam int AMOUNT_W = 32;
	localparam int VALUE_W  = 32;
	localparam int CFG_W    = 11;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TOTAL_W-1:0]     total_t;
	typedef logic [WIDE_W-1:0]      wide_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [IN_USE_W-1:0]    in_use_t;

	localparam count_t COUNT_MAX = '1;
	localparam total_t TOTAL_MAX = '1;

	// Bins in use after reset, limited to the table size.
	localparam int RESET_IN_USE_RAW = 1024;
	localparam int RESET_IN_USE     = (RESET_IN_USE_RAW > BIN_CAPACITY) ?
		BIN_CAPACITY : RESET_IN_USE_RAW;

	// Operation codes carried in the func field.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_READ  = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_ADD   = 2'd2,
		FUNC_CLEAR = 2'd3
	} hbt_func_e;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} hbt_state_e;

	// Input beat.
	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [INDEX_W-1:0]  bin_index;
		logic [AMOUNT_W-1:0] amount;
	} hbt_in_t;

	// Result beat.
	typedef struct packed {
		logic                accepted;
		logic [VALUE_W-1:0]  bin_value;
		logic [TOTAL_W-1:0]  total_count;
	} hbt_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
		logic sweep_start;
		logic sweep_step;
	} hbt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic sweep_last;
	} hbt_sts_t;

	// Limit an incoming amount to the largest count a bin can hold.
	function automatic count_t sat_amount(logic [AMOUNT_W-1:0] a);
		wide_t w;
		w = WIDE_W'(a);
		if (w > WIDE_W'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_WIDTH'(w);
	endfunction

	// Limit a widened total to the largest total.
	function automatic total_t sat_total(wide_t x);
		if (x > WIDE_W'(TOTAL_MAX)) begin
			return TOTAL_MAX;
		end
		return TOTAL_W'(x);
	endfunction

endpackage

/* rtl/hbt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module hbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/hbt_ctrl.sv */
// Controller state machine: sequences capture, execute and the clearing sweep.
module hbt_ctrl
	import hbt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  logic     cfg_we,
	input  hbt_sts_t sts,
	output hbt_cmd_t cmd
);

	hbt_state_e state_q, state_d;
	logic       out_valid_q;
	logic       ready_c;

	// State register and result-valid flag; reset starts a clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.execute | (out_valid_q & ~out_ready);
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ready_c = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready_c = ~cfg_we;
				if (in_valid && !cfg_we) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result slot must be free or draining in this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.execute     = 1'b1;
					cmd.sweep_start = sts.is_clear;
					state_d         = sts.is_clear ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		// A register write clears the table and restarts the sweep.
		if (cfg_we) begin
			cmd     = '0;
			cmd.sweep_start = 1'b1;
			state_d = ST_CLEAR;
		end
	end

	assign in_ready  = ready_c;
	assign out_valid = out_valid_q;

endmodule

/* rtl/hbt_datapath.sv */
// Datapath: bin memory, running total, bins-in-use register and result register.
module hbt_datapath
	import hbt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  hbt_in_t          in_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  hbt_cmd_t         cmd,
	output hbt_sts_t         sts,
	output hbt_out_t         out_data
);

	// Item held between capture and execute.
	hbt_func_e func_q;
	logic      in_range_q;
	addr_t     addr_q;
	count_t    amt_q;
	wide_t     pre_amt_q;
	wide_t     pre_cmax_q;

	total_t    total_q;
	in_use_t   in_use_q;
	addr_t     sweep_cnt_q;
	hbt_out_t  out_q;

	count_t    old_bin;
	count_t    amt_in;
	logic      in_range_c;
	logic [COUNT_WIDTH:0] bin_sum;
	logic      bin_ovf;
	count_t    new_bin;
	total_t    new_total;
	wide_t     diff_amt;
	wide_t     diff_cmax;
	logic      bin_write;

	logic      ram_we;
	addr_t     ram_waddr;
	count_t    ram_wdata;

	// Range check and amount limit on the incoming beat.
	assign amt_in     = sat_amount(in_data.amount);
	assign in_range_c = (32'(in_data.bin_index) < 32'(in_use_q));

	// Capture the item and the two candidate sums of the total.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= hbt_func_e'(in_data.func);
			in_range_q <= in_range_c;
			addr_q     <= ADDR_W'(in_data.bin_index);
			amt_q      <= amt_in;
			pre_amt_q  <= WIDE_W'(total_q) + WIDE_W'(amt_in);
			pre_cmax_q <= WIDE_W'(total_q) + WIDE_W'(COUNT_MAX);
		end
	end

	// New bin value.
	assign bin_sum = {1'b0, old_bin} + {1'b0, amt_q};
	assign bin_ovf = bin_sum[COUNT_WIDTH];
	assign diff_amt  = pre_amt_q - WIDE_W'(old_bin);
	assign diff_cmax = pre_cmax_q - WIDE_W'(old_bin);

	always_comb begin
		new_bin   = old_bin;
		new_total = total_q;
		case (func_q)
			FUNC_SET: begin
				new_bin = amt_q;
				// The total floors at zero before the new count goes in.
				if (WIDE_W'(total_q) >= WIDE_W'(old_bin)) begin
					new_total = sat_total(diff_amt);
				end else begin
					new_total = TOTAL_W'(amt_q);
				end
			end
			FUNC_ADD: begin
				// On bin overflow only the room left in the bin reaches the total.
				if (bin_ovf) begin
					new_bin   = COUNT_MAX;
					new_total = sat_total(diff_cmax);
				end else begin
					new_bin   = bin_sum[COUNT_WIDTH-1:0];
					new_total = sat_total(pre_amt_q);
				end
			end
			FUNC_READ: begin
				new_bin   = old_bin;
				new_total = total_q;
			end
			default: begin
				new_bin   = '0;
				new_total = '0;
			end
		endcase
	end

	assign bin_write = cmd.execute && in_range_q &&
		(func_q == FUNC_SET || func_q == FUNC_ADD);

	// Running total, bins in use and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			in_use_q    <= IN_USE_W'(RESET_IN_USE);
			sweep_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				total_q <= '0;
				if (32'(cfg_wdata) > 32'(BIN_CAPACITY)) begin
					in_use_q <= IN_USE_W'(BIN_CAPACITY);
				end else begin
					in_use_q <= IN_USE_W'(cfg_wdata);
				end
			end else if (cmd.execute) begin
				if (func_q == FUNC_CLEAR) begin
					total_q <= '0;
				end else if (in_range_q) begin
					total_q <= new_total;
				end
			end
			if (cmd.sweep_start) begin
				sweep_cnt_q <= '0;
			end else if (cmd.sweep_step) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
		end
	end

	// Result register, loaded when the item executes.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (func_q == FUNC_CLEAR) begin
				out_q.accepted    <= 1'b1;
				out_q.bin_value   <= '0;
				out_q.total_count <= '0;
			end else if (in_range_q) begin
				out_q.accepted    <= 1'b1;
				out_q.bin_value   <= VALUE_W'(new_bin);
				out_q.total_count <= new_total;
			end else begin
				out_q.accepted    <= 1'b0;
				out_q.bin_value   <= '0;
				out_q.total_count <= total_q;
			end
		end
	end

	// Memory write port: the sweep writes zeros, otherwise the updated bin.
	assign ram_we    = cmd.sweep_step | bin_write;
	assign ram_waddr = cmd.sweep_step ? sweep_cnt_q : addr_q;
	assign ram_wdata = cmd.sweep_step ? '0 : new_bin;

	hbt_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (BIN_CAPACITY)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (ADDR_W'(in_data.bin_index)),
		.rdata (old_bin)
	);

	assign sts.is_clear   = (func_q == FUNC_CLEAR);
	assign sts.sweep_last = (sweep_cnt_q == ADDR_W'(BIN_CAPACITY - 1));
	assign out_data       = out_q;

endmodule

/* rtl/histogram_bin_table_unit.sv */
// Histogram bin table: top level joining the controller and the datapath.
// A result beat is registered when its item executes, once the result slot is free.
// One item is handled at a time, for the read-modify-write of the bin RAM.
// A clear operation returns its result, then sweeps all 1024 bins of the RAM (one bin
// a cycle) while no input is taken; a register write starts the same sweep.
// Reset (arst_n low) zeroes the total, sets 1024 bins in use and runs the same sweep.
module histogram_bin_table_unit
	import hbt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hbt_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output hbt_out_t         out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	hbt_cmd_t cmd;
	hbt_sts_t sts;

	hbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.sts       (sts),
		.cmd       (cmd)
	);

	hbt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

/* rtl/hbt_checker.sv */
// Port-level checker for the histogram bin table, bound to the top level.
module hbt_checker
	import hbt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input hbt_in_t          in_data,
	input logic             out_valid,
	input logic             out_ready,
	input hbt_out_t         out_data,
	input logic             cfg_we,
	input logic [CFG_W-1:0] cfg_wdata
);

	// A result beat that is not taken stays, unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	// A rejected operation reads a bin value of zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.bin_value == '0)
		else $error("rejected beat carries a non-zero bin value");

	// One item at a time: no input is taken in the cycle after an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the execute cycle");

	// A register write starts the clearing sweep, which holds off input.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken right after a register write");

endmodule

bind histogram_bin_table_unit hbt_checker u_hbt_checker (.*);
